// ===== rtl/ut2lc_pkg.sv =====
// Package for the Unix time to local calendar converter.
// Holds the calendar constants and the small helper functions.
// Used by ut2lc_zone and unix_time_to_local_calendar; depends on nothing.
package ut2lc_pkg;

  localparam int unsigned TsW     = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned OffW    = 5;

  localparam logic [OffW-1:0] OFFSET_RESET = 5'd1;

  // Julian day of the Unix epoch plus the offset of the integer date formula.
  localparam logic [21:0] JD_BIAS = 22'(2440588 + 68569);
  localparam logic [6:0]  CENT_BIAS = 7'd49;

  localparam logic [MonthW-1:0] MONTH_MAR = 4'd3;
  localparam logic [MonthW-1:0] MONTH_APR = 4'd4;
  localparam logic [MonthW-1:0] MONTH_SEP = 4'd9;
  localparam logic [MonthW-1:0] MONTH_OCT = 4'd10;

  localparam logic [HourW-1:0] DST_START_HOUR = 5'd2;
  localparam logic [HourW-1:0] DST_END_HOUR   = 5'd3;

  // Remainder modulo 7 of a ten-bit value, folding octal digits since 8 = 1 mod 7.
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  // Days before the shifted month s, that is floor(2447 * s / 80).
  function automatic logic [8:0] month_base(input logic [3:0] s);
    logic [8:0] b;
    unique case (s)
      4'd0:  b = 9'd0;
      4'd1:  b = 9'd30;
      4'd2:  b = 9'd61;
      4'd3:  b = 9'd91;
      4'd4:  b = 9'd122;
      4'd5:  b = 9'd152;
      4'd6:  b = 9'd183;
      4'd7:  b = 9'd214;
      4'd8:  b = 9'd244;
      4'd9:  b = 9'd275;
      4'd10: b = 9'd305;
      4'd11: b = 9'd336;
      4'd12: b = 9'd367;
      4'd13: b = 9'd397;
      4'd14: b = 9'd428;
      default: b = 9'd458;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/ut2lc_cdiv.sv =====
// Pipelined division of an unsigned value by a constant, with quotient and remainder.
// Three register stages: input, reciprocal product, corrected result; side data follows.
// Self-contained; no package needed.
module ut2lc_cdiv #(
  parameter int unsigned XW = 16,
  parameter int unsigned D  = 3,
  parameter int unsigned QW = 8,
  parameter int unsigned SW = 1,
  localparam int unsigned RW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o,
  output logic [SW-1:0] side_o
);

  localparam longint unsigned M = (64'd1 << XW) / D;
  localparam int unsigned MW = $clog2(M + 1);
  localparam int unsigned PW = XW + MW;

  logic          v0_q, v1_q, v2_q;
  logic          en0, en1, en2;
  logic [XW-1:0] x0_q, x1_q;
  logic [SW-1:0] s0_q, s1_q, s2_q;
  logic [PW-1:0] prod_d, prod_q;
  logic [MW-1:0] qe;
  logic [XW-1:0] re;
  logic          corr;
  logic [QW-1:0] q_d, q_q;
  logic [RW-1:0] r_d, r_q;

  assign en2     = !v2_q || !stall_i;
  assign en1     = !v1_q || en2;
  assign en0     = !v0_q || en1;
  assign stall_o = !en0;

  assign prod_d = PW'(x0_q) * PW'(M);
  assign qe     = prod_q[PW-1:XW];
  assign re     = x1_q - XW'(XW'(qe) * XW'(D));
  assign corr   = (re >= XW'(D));
  assign q_d    = QW'(qe) + QW'(corr);
  assign r_d    = corr ? RW'(re - XW'(D)) : RW'(re);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      x0_q <= x_i;
      s0_q <= side_i;
    end
    if (en1) begin
      x1_q   <= x0_q;
      prod_q <= prod_d;
      s1_q   <= s0_q;
    end
    if (en2) begin
      q_q  <= q_d;
      r_q  <= r_d;
      s2_q <= s1_q;
    end
  end

  assign valid_o = v2_q;
  assign q_o     = q_q;
  assign r_o     = r_q;
  assign side_o  = s2_q;

endmodule

// ===== rtl/ut2lc_zone.sv =====
// Final stages: calendar fields from the date formula, last Sundays, summer time, local hour.
// Three register stages, the last of which is the output register.
// Depends on ut2lc_pkg.
module ut2lc_zone
  import ut2lc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OffW-1:0]   offset_i,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [6:0]        cq_i,
  input  logic [6:0]        yr_i,
  input  logic [3:0]        ms_i,
  input  logic [8:0]        p2_i,
  input  logic [HourW-1:0]  hour_i,
  input  logic [MinW-1:0]   minute_i,
  input  logic [SecW-1:0]   second_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [YearW-1:0]  year_o,
  output logic [MonthW-1:0] month_o,
  output logic [DayW-1:0]   day_o,
  output logic [HourW-1:0]  utc_hour_o,
  output logic [MinW-1:0]   minute_o,
  output logic [SecW-1:0]   second_o,
  output logic              summer_time_o,
  output logic [HourW-1:0]  local_hour_o
);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } cal_t;

  logic        v1_q, v2_q, v3_q;
  logic        en1, en2, en3;
  cal_t        c1_d, c1_q, c2_q, c3_q;
  logic [9:0]  base_d, base_q;
  logic [4:0]  mar_d, mar_q, oct_d, oct_q;
  logic        jan_feb;
  logic [6:0]  yy, cen, kk, jj;
  logic        wrap;
  logic        dst_d, dst_q;
  logic [5:0]  lsum;
  logic [HourW-1:0] local_d, local_q;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  always_comb begin
    jan_feb      = (ms_i > 4'd10);
    c1_d.month   = jan_feb ? 4'(ms_i - 4'd10) : 4'(ms_i + 4'd2);
    c1_d.day     = 5'(p2_i - month_base(ms_i));
    yy           = 7'(yr_i + 7'(jan_feb));
    cen          = 7'(cq_i - CENT_BIAS);
    wrap         = (yy >= 7'd100);
    kk           = wrap ? 7'(yy - 7'd100) : yy;
    jj           = wrap ? 7'(cen + 7'd1) : cen;
    c1_d.year    = 12'(12'(cen) * 12'd100 + 12'(yy));
    c1_d.hour    = hour_i;
    c1_d.minute  = minute_i;
    c1_d.second  = second_i;
    base_d       = 10'(kk) + 10'(kk >> 2) + 10'(jj >> 2) + 10'(10'(jj) * 10'd5);
  end

  assign mar_d = 5'd31 - 5'(mod7(10'(base_q + 10'd47)));
  assign oct_d = 5'd31 - 5'(mod7(10'(base_q + 10'd65)));

  always_comb begin
    case (c2_q.month) inside
      MONTH_MAR: begin
        dst_d = (c2_q.day > mar_q) ||
                ((c2_q.day == mar_q) && (c2_q.hour >= DST_START_HOUR));
      end
      MONTH_OCT: begin
        dst_d = (c2_q.day < oct_q) ||
                ((c2_q.day == oct_q) && (c2_q.hour < DST_END_HOUR));
      end
      [MONTH_APR:MONTH_SEP]: dst_d = 1'b1;
      default: dst_d = 1'b0;
    endcase
    lsum = 6'(c2_q.hour) + 6'(offset_i) + 6'(dst_d);
    if (lsum >= 6'd48) begin
      local_d = 5'(lsum - 6'd48);
    end else if (lsum >= 6'd24) begin
      local_d = 5'(lsum - 6'd24);
    end else begin
      local_d = 5'(lsum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q   <= c1_d;
      base_q <= base_d;
    end
    if (en2) begin
      c2_q  <= c1_q;
      mar_q <= mar_d;
      oct_q <= oct_d;
    end
    if (en3) begin
      c3_q    <= c2_q;
      dst_q   <= dst_d;
      local_q <= local_d;
    end
  end

  assign valid_o       = v3_q;
  assign year_o        = c3_q.year;
  assign month_o       = c3_q.month;
  assign day_o         = c3_q.day;
  assign utc_hour_o    = c3_q.hour;
  assign minute_o      = c3_q.minute;
  assign second_o      = c3_q.second;
  assign summer_time_o = dst_q;
  assign local_hour_o  = local_q;

endmodule

// ===== rtl/unix_time_to_local_calendar.sv =====
// Unix timestamp to UTC calendar date, European summer-time flag and local hour.
// Top level: configuration register, glue between the divider stages, final stage.
// Depends on ut2lc_pkg, ut2lc_cdiv and ut2lc_zone.
//
// The converter accepts one timestamp per clock cycle while in_stall_o is low and
// returns the results in order. Each result passes through six constant dividers
// of three register stages each, followed by the three stages that form the date,
// find the last Sundays and add the offset. Stalls hold every stage that is
// full; bubbles close up, so input is still taken while a result waits. The
// offset register is best written while no transaction is in flight; it resets
// to 1 and is always ready.
module unix_time_to_local_calendar
  import ut2lc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [OffW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TsW-1:0]    timestamp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [YearW-1:0]  year_o,
  output logic [MonthW-1:0] month_o,
  output logic [DayW-1:0]   day_o,
  output logic [HourW-1:0]  utc_hour_o,
  output logic [MinW-1:0]   minute_o,
  output logic [SecW-1:0]   second_o,
  output logic              summer_time_o,
  output logic [HourW-1:0]  local_hour_o
);

  logic [OffW-1:0] offset_q;

  logic        v1, st1, v2, st2, v3, st3, v4, st4, v5, st5, v6, st6;
  logic [15:0] d1_q;
  logic [9:0]  d1_r;
  logic [6:0]  d1_s;
  logic [16:0] sod;
  logic [4:0]  d2_q;
  logic [7:0]  d2_r;
  logic [19:0] d2_s;
  logic [11:0] remh;
  logic [5:0]  d3_q;
  logic [3:0]  d3_r;
  logic [22:0] d3_s;
  logic [16:0] tod3;
  logic [21:0] p0;
  logic [6:0]  d4_q;
  logic [17:0] d4_r;
  logic [16:0] d4_s;
  logic [15:0] p1;
  logic [27:0] x5;
  logic [6:0]  d5_q;
  logic [39:0] d5_s;
  logic [17:0] p2_full;
  logic [8:0]  p2;
  logic [15:0] x6;
  logic [3:0]  d6_q;
  logic [39:0] d6_s;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      offset_q <= cfg_data_i;
    end
  end

  // Day count and second of day: 86400 = 128 * 675.
  ut2lc_cdiv #(.XW(25), .D(675), .QW(16), .SW(7)) u_div_day (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .stall_o(in_stall_o),
    .x_i(timestamp_i[31:7]), .side_i(timestamp_i[6:0]),
    .valid_o(v1), .stall_i(st1),
    .q_o(d1_q), .r_o(d1_r), .side_o(d1_s)
  );

  assign sod = {d1_r, d1_s};

  // Hour of day: 3600 = 16 * 225.
  ut2lc_cdiv #(.XW(13), .D(225), .QW(5), .SW(20)) u_div_hour (
    .clk_i, .rst_ni,
    .valid_i(v1), .stall_o(st1),
    .x_i(sod[16:4]), .side_i({d1_q, sod[3:0]}),
    .valid_o(v2), .stall_i(st2),
    .q_o(d2_q), .r_o(d2_r), .side_o(d2_s)
  );

  assign remh = {d2_r, d2_s[3:0]};

  // Minute and second: 60 = 4 * 15.
  ut2lc_cdiv #(.XW(10), .D(15), .QW(6), .SW(23)) u_div_min (
    .clk_i, .rst_ni,
    .valid_i(v2), .stall_o(st2),
    .x_i(remh[11:2]), .side_i({d2_s[19:4], d2_q, remh[1:0]}),
    .valid_o(v3), .stall_i(st3),
    .q_o(d3_q), .r_o(d3_r), .side_o(d3_s)
  );

  assign tod3 = {d3_s[6:2], d3_q, d3_r, d3_s[1:0]};
  assign p0   = 22'(d3_s[22:7]) + JD_BIAS;

  // Gregorian four-century cycle; the day within it is the remainder over four.
  ut2lc_cdiv #(.XW(24), .D(146097), .QW(7), .SW(17)) u_div_cent (
    .clk_i, .rst_ni,
    .valid_i(v3), .stall_o(st3),
    .x_i({p0, 2'b00}), .side_i(tod3),
    .valid_o(v4), .stall_i(st4),
    .q_o(d4_q), .r_o(d4_r), .side_o(d4_s)
  );

  assign p1 = d4_r[17:2];
  assign x5 = 28'((28'(p1) + 28'd1) * 28'd4000);

  ut2lc_cdiv #(.XW(28), .D(1461001), .QW(7), .SW(40)) u_div_year (
    .clk_i, .rst_ni,
    .valid_i(v4), .stall_o(st4),
    .x_i(x5), .side_i({d4_s, d4_q, p1}),
    .valid_o(v5), .stall_i(st5),
    .q_o(d5_q), .r_o(), .side_o(d5_s)
  );

  assign p2_full = 18'(d5_s[15:0]) + 18'd31 - ((18'(d5_q) * 18'd1461) >> 2);
  assign p2      = p2_full[8:0];
  assign x6      = 16'(16'(p2) * 16'd80);

  ut2lc_cdiv #(.XW(16), .D(2447), .QW(4), .SW(40)) u_div_month (
    .clk_i, .rst_ni,
    .valid_i(v5), .stall_o(st5),
    .x_i(x6), .side_i({d5_s[39:23], d5_s[22:16], d5_q, p2}),
    .valid_o(v6), .stall_i(st6),
    .q_o(d6_q), .r_o(), .side_o(d6_s)
  );

  ut2lc_zone u_zone (
    .clk_i, .rst_ni,
    .offset_i(offset_q),
    .valid_i(v6), .stall_o(st6),
    .cq_i(d6_s[22:16]), .yr_i(d6_s[15:9]), .ms_i(d6_q), .p2_i(d6_s[8:0]),
    .hour_i(d6_s[39:35]), .minute_i(d6_s[34:29]), .second_i(d6_s[28:23]),
    .valid_o(out_valid_o), .stall_i(out_stall_i),
    .year_o, .month_o, .day_o, .utc_hour_o, .minute_o, .second_o,
    .summer_time_o, .local_hour_o
  );

endmodule
